>>> src/sqdb_pkg.sv
// Shared types and constants for the stack / queue / deque buffer.
// No dependencies; used by every other file of the block.
package sqdb_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd3;

    localparam logic REG_ADD_AT_BACK    = 1'b0;
    localparam logic REG_REMOVE_AT_BACK = 1'b1;

    typedef struct packed {
        logic add_at_back;
        logic remove_at_back;
    } cfg_t;

    typedef struct packed {
        logic add;
        logic remove;
        logic clear;
        logic dump_start;
        logic rd_step;
        logic rd_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
    } dp_status_t;

endpackage

>>> src/sqdb_ifs.sv
// Valid/ready channel interfaces for operations and results.
// Depends on sqdb_pkg for field widths.
interface sqdb_op_if;
    logic                                valid;
    logic                                ready;
    logic [sqdb_pkg::FUNC_W-1:0]         func;
    logic signed [sqdb_pkg::VALUE_W-1:0] item_value;

    modport source (output valid, output func, output item_value, input ready);
    modport sink (input valid, input func, input item_value, output ready);
endinterface

interface sqdb_res_if;
    logic                                valid;
    logic                                ready;
    logic [sqdb_pkg::STATUS_W-1:0]       status;
    logic signed [sqdb_pkg::VALUE_W-1:0] result_value;
    logic [sqdb_pkg::TOTAL_W-1:0]        entry_total;
    logic                                last_of_run;

    modport source (output valid, output status, output result_value,
                    output entry_total, output last_of_run, input ready);
    modport sink (input valid, input status, input result_value,
                  input entry_total, input last_of_run, output ready);
endinterface

>>> src/sqdb_regs.sv
// APB configuration registers: add_at_back (index 0), remove_at_back (index 1).
// Depends on sqdb_pkg.
module sqdb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqdb_pkg::APB_AW-1:0]   paddr,
    input  logic [sqdb_pkg::APB_DW-1:0]   pwdata,
    output logic [sqdb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output sqdb_pkg::cfg_t                cfg
);
    logic add_at_back_reg;
    logic remove_at_back_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_at_back_reg    <= 1'b0;
            remove_at_back_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                sqdb_pkg::REG_ADD_AT_BACK:    add_at_back_reg    <= pwdata[0];
                sqdb_pkg::REG_REMOVE_AT_BACK: remove_at_back_reg <= pwdata[0];
                default:                      add_at_back_reg    <= add_at_back_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            sqdb_pkg::REG_ADD_AT_BACK:    prdata[0] = add_at_back_reg;
            sqdb_pkg::REG_REMOVE_AT_BACK: prdata[0] = remove_at_back_reg;
            default:                      prdata    = '0;
        endcase
    end

    assign cfg.add_at_back    = add_at_back_reg;
    assign cfg.remove_at_back = remove_at_back_reg;

endmodule

>>> src/sqdb_dp.sv
// Datapath: ring memory, front pointer, entry count, dump walker.
// Depends on sqdb_pkg; driven by sqdb_ctrl commands.
module sqdb_dp #(
    parameter int DEPTH = sqdb_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sqdb_pkg::cfg_t                      cfg,
    input  sqdb_pkg::dp_cmd_t                   cmd,
    input  logic signed [sqdb_pkg::VALUE_W-1:0] item_value,
    output sqdb_pkg::dp_status_t                status,
    output logic signed [sqdb_pkg::VALUE_W-1:0] result_value,
    output logic [sqdb_pkg::TOTAL_W-1:0]        entry_total
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

    logic signed [sqdb_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [sqdb_pkg::VALUE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] front_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] walk_ptr_reg;
    logic [CNT_W-1:0] walk_left_reg;

    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] walk_inc;
    logic [IDX_W-1:0] walk_dec;
    logic [SUM_W-1:0] back_sum;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] back_pos;
    logic [IDX_W-1:0] tail_pos;
    logic [IDX_W-1:0] wr_addr;

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign walk_inc  = (walk_ptr_reg == LAST_IDX) ? '0 : walk_ptr_reg + 1'b1;
    assign walk_dec  = (walk_ptr_reg == '0) ? LAST_IDX : walk_ptr_reg - 1'b1;

    assign back_sum = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign tail_sum = back_sum - 1'b1;
    assign back_pos = (back_sum >= DEPTH_S) ? IDX_W'(back_sum - DEPTH_S) : IDX_W'(back_sum);
    assign tail_pos = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
    assign wr_addr  = cfg.add_at_back ? back_pos : front_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            walk_ptr_reg  <= '0;
            walk_left_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                front_reg <= '0;
                count_reg <= '0;
            end
            else if (cmd.add)
            begin
                if (!cfg.add_at_back)
                begin
                    front_reg <= front_dec;
                end
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.remove)
            begin
                if (!cfg.remove_at_back)
                begin
                    front_reg <= front_inc;
                end
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.dump_start)
            begin
                walk_ptr_reg  <= cfg.add_at_back ? tail_pos : front_reg;
                walk_left_reg <= count_reg;
            end
            else if (cmd.rd_step)
            begin
                walk_ptr_reg  <= cfg.add_at_back ? walk_dec : walk_inc;
                walk_left_reg <= walk_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            mem[wr_addr] <= item_value;
        end
        if (cmd.rd_clr)
        begin
            rd_data_reg <= '0;
        end
        else if (cmd.rd_step)
        begin
            rd_data_reg <= mem[walk_ptr_reg];
        end
    end

    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == CNT_W'(DEPTH));
    assign status.walk_last = (walk_left_reg == CNT_W'(1));
    assign result_value     = rd_data_reg;
    assign entry_total      = sqdb_pkg::TOTAL_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_no_add_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> !status.full)
        else $error("add issued on full store");

    a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_step |-> walk_left_reg != '0)
        else $error("dump read past last entry");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add && !cmd.clear |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not bump count");

endmodule

>>> src/sqdb_ctrl.sv
// Control FSM: decodes operations, sequences dump reads, holds result status.
// Depends on sqdb_pkg; commands sqdb_dp.
module sqdb_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           op_valid,
    output logic                           op_ready,
    input  logic [sqdb_pkg::FUNC_W-1:0]    func,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [sqdb_pkg::STATUS_W-1:0]  status,
    output logic                           last_of_run,
    input  sqdb_pkg::dp_status_t           dp_status,
    output sqdb_pkg::dp_cmd_t              cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    state_t                        state_reg;
    logic [sqdb_pkg::STATUS_W-1:0] status_reg;
    logic                          last_reg;
    logic                          accept;
    logic                          dump_go;

    assign op_ready    = (state_reg == S_IDLE);
    assign accept      = op_valid & op_ready;
    assign dump_go     = (func == sqdb_pkg::FUNC_DUMP) & !dp_status.empty;
    assign res_valid   = (state_reg == S_RESP) || (state_reg == S_DUMP_OUT);
    assign status      = status_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.rd_clr = !dump_go;
                    unique case (func)
                        sqdb_pkg::FUNC_ADD:    cmd.add        = !dp_status.full;
                        sqdb_pkg::FUNC_REMOVE: cmd.remove     = !dp_status.empty;
                        sqdb_pkg::FUNC_CLEAR:  cmd.clear      = 1'b1;
                        sqdb_pkg::FUNC_DUMP:   cmd.dump_start = !dp_status.empty;
                        default:               cmd.clear      = 1'b0;
                    endcase
                end
            end
            S_DUMP_RD:  cmd.rd_step = 1'b1;
            S_DUMP_OUT: cmd.rd_step = res_ready & !last_reg;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= sqdb_pkg::ST_DONE;
            last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg  <= 1'b1;
                        state_reg <= dump_go ? S_DUMP_RD : S_RESP;
                        unique case (func)
                            sqdb_pkg::FUNC_ADD:
                                status_reg <= dp_status.full ? sqdb_pkg::ST_FULL
                                                             : sqdb_pkg::ST_DONE;
                            sqdb_pkg::FUNC_REMOVE:
                                status_reg <= dp_status.empty ? sqdb_pkg::ST_EMPTY
                                                              : sqdb_pkg::ST_DONE;
                            sqdb_pkg::FUNC_CLEAR:
                                status_reg <= sqdb_pkg::ST_DONE;
                            sqdb_pkg::FUNC_DUMP:
                                status_reg <= dp_status.empty ? sqdb_pkg::ST_EMPTY
                                                              : sqdb_pkg::ST_ENTRY;
                            default:
                                status_reg <= sqdb_pkg::ST_DONE;
                        endcase
                    end
                end
                S_RESP:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DUMP_RD:
                begin
                    last_reg  <= dp_status.walk_last;
                    state_reg <= S_DUMP_OUT;
                end
                S_DUMP_OUT:
                begin
                    if (res_ready)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            last_reg <= dp_status.walk_last;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(op_ready && res_valid))
        else $error("input taken while result pending");

    a_dump_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP_OUT |-> status_reg == sqdb_pkg::ST_ENTRY)
        else $error("dump beat without entry status");

    a_step_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_step && state_reg == S_DUMP_OUT |-> res_ready && !last_reg)
        else $error("dump read advanced without beat taken");

endmodule

>>> src/stack_queue_deque_buffer_top.sv
// Top level of the stack / queue / deque buffer.
// Depends on sqdb_pkg, sqdb_ifs, sqdb_regs, sqdb_ctrl, sqdb_dp.
//
// Bounded double-ended store of DEPTH signed 32-bit words, used as a stack or
// a queue by the add_at_back / remove_at_back registers. One operation is in
// flight at a time. Add, remove and clear are taken in the idle state and give one
// result beat in the next cycle; the next operation is taken the cycle after
// that beat is accepted. A dump of n entries starts with a read setup state,
// then gives one entry per cycle while the sink is ready, paced by the single
// registered read port of the entry memory. No clearing pass runs after reset.
module stack_queue_deque_buffer_top #(
    parameter int DEPTH = sqdb_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    sqdb_op_if.sink                      op_ch,
    sqdb_res_if.source                   res_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sqdb_pkg::APB_AW-1:0]  paddr,
    input  logic [sqdb_pkg::APB_DW-1:0]  pwdata,
    output logic [sqdb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    sqdb_pkg::cfg_t       cfg;
    sqdb_pkg::dp_cmd_t    cmd;
    sqdb_pkg::dp_status_t dp_status;

    sqdb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sqdb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_ch.valid),
        .op_ready    (op_ch.ready),
        .func        (op_ch.func),
        .res_valid   (res_ch.valid),
        .res_ready   (res_ch.ready),
        .status      (res_ch.status),
        .last_of_run (res_ch.last_of_run),
        .dp_status   (dp_status),
        .cmd         (cmd)
    );

    sqdb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .item_value   (op_ch.item_value),
        .status       (dp_status),
        .result_value (res_ch.result_value),
        .entry_total  (res_ch.entry_total)
    );

endmodule

>>> bench/sqdb_checker.sv
// Checker for the stack / queue / deque buffer: mirrors the store, predicts
// every result beat and compares it with what the block sends.
// Depends on sqdb_pkg and the channel interfaces in sqdb_ifs.
module sqdb_checker
    import sqdb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    sqdb_op_if                op_ch,
    sqdb_res_if               res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int unsigned       beats_owed,
    output int unsigned       fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] result_value;
        logic [TOTAL_W-1:0]        entry_total;
        logic                      last_of_run;
    } reply_t;

    reply_t                    reply_beats[$];
    logic signed [VALUE_W-1:0] mirror_words[DEPTH];
    int                        mirror_front;
    int                        mirror_count;
    logic                      mirror_add_back;
    logic                      mirror_rem_back;
    int unsigned               mismatches;

    task automatic queue_reply(input logic [STATUS_W-1:0] st,
                               input logic signed [VALUE_W-1:0] val,
                               input logic last);
        reply_t r;
        begin
            r.status       = st;
            r.result_value = val;
            r.entry_total  = TOTAL_W'(mirror_count);
            r.last_of_run  = last;
            reply_beats.push_back(r);
        end
    endtask

    task automatic apply_buffer_op(input logic [FUNC_W-1:0] f,
                                   input logic signed [VALUE_W-1:0] v);
        int off;
        begin
            case (f)
                FUNC_ADD:
                begin
                    if (mirror_count >= DEPTH)
                    begin
                        queue_reply(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (mirror_add_back)
                        begin
                            mirror_words[(mirror_front + mirror_count) % DEPTH] = v;
                        end
                        else
                        begin
                            mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                            mirror_words[mirror_front] = v;
                        end
                        mirror_count++;
                        queue_reply(ST_DONE, '0, 1'b1);
                    end
                end
                FUNC_REMOVE:
                begin
                    if (mirror_count == 0)
                    begin
                        queue_reply(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        if (!mirror_rem_back)
                        begin
                            mirror_front = (mirror_front + 1) % DEPTH;
                        end
                        mirror_count--;
                        queue_reply(ST_DONE, '0, 1'b1);
                    end
                end
                FUNC_CLEAR:
                begin
                    mirror_front = 0;
                    mirror_count = 0;
                    queue_reply(ST_DONE, '0, 1'b1);
                end
                default:
                begin
                    if (mirror_count == 0)
                    begin
                        queue_reply(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < mirror_count; i++)
                        begin
                            off = mirror_add_back ? (mirror_count - 1 - i) : i;
                            queue_reply(ST_ENTRY,
                                        mirror_words[(mirror_front + off) % DEPTH],
                                        i == mirror_count - 1);
                        end
                    end
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            reply_beats.delete();
            mirror_front    = 0;
            mirror_count    = 0;
            mirror_add_back = 1'b0;
            mirror_rem_back = 1'b0;
            mismatches      = 0;
            beats_owed     <= 0;
            fail_count     <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (reply_beats.size() == 0)
                begin
                    $display("%0t: result beat with none pending: status %0d value %0d total %0d last %0b",
                             $time, res_ch.status, res_ch.result_value,
                             res_ch.entry_total, res_ch.last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = reply_beats.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res_ch.status);
                        mismatches++;
                    end
                    if (res_ch.result_value !== want.result_value)
                    begin
                        $display("%0t: result_value expected %0d actual %0d",
                                 $time, want.result_value, res_ch.result_value);
                        mismatches++;
                    end
                    if (res_ch.entry_total !== want.entry_total)
                    begin
                        $display("%0t: entry_total expected %0d actual %0d",
                                 $time, want.entry_total, res_ch.entry_total);
                        mismatches++;
                    end
                    if (res_ch.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last_of_run, res_ch.last_of_run);
                        mismatches++;
                    end
                end
            end
            if (op_ch.valid && op_ch.ready)
            begin
                apply_buffer_op(op_ch.func, op_ch.item_value);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_AW-1:2])
                    REG_ADD_AT_BACK:    mirror_add_back = pwdata[0];
                    REG_REMOVE_AT_BACK: mirror_rem_back = pwdata[0];
                    default: ;
                endcase
            end
            beats_owed <= reply_beats.size();
            fail_count <= mismatches;
        end
    end

endmodule

>>> bench/tb_top.sv
// Top of the buffer testbench: clock, reset, APB mode writes and operation
// stimulus with random idling; sqdb_checker supplies the failure count.
// Depends on sqdb_pkg, sqdb_ifs, stack_queue_deque_buffer_top, sqdb_checker.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sqdb_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int TAIL_CYCLES = DEPTH + 8;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int unsigned       beats_owed;
    int unsigned       fail_count;
    logic              calm;
    logic              squeeze;
    int                ops_sent;

    sqdb_op_if  op_ch();
    sqdb_res_if res_ch();

    stack_queue_deque_buffer_top #(.DEPTH(DEPTH)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_ch   (op_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sqdb_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_ch      (op_ch),
        .res_ch     (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .beats_owed (beats_owed),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off while squeeze is up
    initial
    begin : sink_side
        int   hold_left;
        logic held;
        hold_left = 0;
        held      = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (squeeze && !held)
            begin
                held      = 1'b1;
                hold_left = 80;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return VALUE_W'($urandom_range(0, 15));
            3:       return -VALUE_W'($urandom_range(1, 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [FUNC_W-1:0] f,
                           input logic signed [VALUE_W-1:0] v);
        begin
            if (!calm)
            begin
                while ($urandom_range(0, 99) < 16)
                begin
                    op_ch.valid <= 1'b0;
                    @(posedge clk);
                end
            end
            op_ch.valid      <= 1'b1;
            op_ch.func       <= f;
            op_ch.item_value <= v;
            @(posedge clk);
            while (!op_ch.ready)
            begin
                @(posedge clk);
            end
            ops_sent++;
        end
    endtask

    task automatic settle();
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
            while (beats_owed != 0)
            begin
                @(posedge clk);
            end
            repeat (TAIL_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= {{(APB_DW-1){1'b0}}, val};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
            begin
                @(posedge clk);
            end
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_mode(input logic add_back, input logic rem_back);
        begin
            settle();
            write_reg(REG_ADD_AT_BACK, add_back);
            write_reg(REG_REMOVE_AT_BACK, rem_back);
            @(posedge clk);
        end
    endtask

    task automatic run_random(input int n_items);
        int goal;
        int pick;
        int k;
        begin
            goal = ops_sent + n_items;
            while (ops_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    k = $urandom_range(0, 99);
                    if (k < 50)
                        send_op(FUNC_ADD, pick_value());
                    else if (k < 75)
                        send_op(FUNC_REMOVE, pick_value());
                    else if (k < 93)
                        send_op(FUNC_DUMP, pick_value());
                    else
                        send_op(FUNC_CLEAR, pick_value());
                end
                else if (pick < 70)
                begin
                    repeat ($urandom_range(6, 20)) send_op(FUNC_ADD, pick_value());
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(4, 18)) send_op(FUNC_REMOVE, pick_value());
                end
                else if (pick < 95)
                begin
                    repeat ($urandom_range(1, 5)) send_op(FUNC_ADD, pick_value());
                    send_op(FUNC_DUMP, pick_value());
                end
                else
                begin
                    send_op(FUNC_CLEAR, pick_value());
                    send_op(FUNC_DUMP, pick_value());
                end
            end
        end
    endtask

    initial
    begin
        calm     = 1'b0;
        squeeze  = 1'b0;
        ops_sent = 0;
        rst_n            <= 1'b0;
        op_ch.valid      <= 1'b0;
        op_ch.func       <= FUNC_ADD;
        op_ch.item_value <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stack mode, directed corners
        set_mode(1'b0, 1'b0);
        send_op(FUNC_DUMP, 32'sh0);
        send_op(FUNC_REMOVE, 32'sh0);
        send_op(FUNC_ADD, 32'sh7fffffff);
        send_op(FUNC_ADD, 32'sh80000000);
        send_op(FUNC_ADD, 32'sh0);
        send_op(FUNC_ADD, -32'sh1);
        send_op(FUNC_DUMP, -32'sh1);
        send_op(FUNC_REMOVE, 32'sh7fffffff);
        send_op(FUNC_CLEAR, 32'sh80000000);
        send_op(FUNC_DUMP, 32'sh0);
        send_op(FUNC_ADD, 32'sh5);
        send_op(FUNC_REMOVE, 32'sh0);
        send_op(FUNC_REMOVE, 32'sh0);
        run_random(80);

        // queue mode; receiver holds off while adds keep coming
        set_mode(1'b1, 1'b0);
        squeeze = 1'b1;
        repeat (DEPTH + 6) send_op(FUNC_ADD, pick_value());
        squeeze = 1'b0;
        send_op(FUNC_DUMP, 32'sh0);
        run_random(80);

        set_mode(1'b0, 1'b1);
        calm = 1'b1;
        run_random(80);
        calm = 1'b0;

        set_mode(1'b1, 1'b1);
        run_random(80);

        set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_random(80);

        settle();
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
